### rtl/tch_pkg.sv
// Shared constants, types and helpers for the TDC coincidence histogram.
package tch_pkg;

    localparam int HALF_WINDOW = 10;
    localparam int COUNT_BITS  = 32;
    localparam int NUM_BINS    = 2 * HALF_WINDOW + 1;
    localparam int CENTRE_BIN  = HALF_WINDOW;
    localparam int BIN_W       = $clog2(NUM_BINS);

    localparam int CMD_W  = 2;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 5;
    localparam int VAL_W  = 32;
    localparam int PAT_W  = 5;
    localparam int TICK_W = WORD_W - PAT_W;

    localparam logic [PAT_W-1:0] PAT_CH2  = 5'd2;
    localparam logic [PAT_W-1:0] PAT_CH4  = 5'd8;
    localparam logic [PAT_W-1:0] PAT_BOTH = 5'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_EVENT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_BUMP  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op_kind;

    typedef enum logic [1:0] {
        SEL_BIN  = 2'd0,
        SEL_CH2  = 2'd1,
        SEL_CH4  = 2'd2,
        SEL_NONE = 2'd3
    } t_sel;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        t_op_kind         kind;
        t_sel             sel;
        logic             bin_en;
        logic [BIN_W-1:0] bin_addr;
        logic             ch2_inc;
        logic             ch4_inc;
    } t_op;

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

    function automatic logic [VAL_W-1:0] clip_value(input t_count c);
        logic [63:0] w;
        w = 64'(c);
        if (w[63:VAL_W] != '0) begin
            return '1;
        end
        return w[VAL_W-1:0];
    endfunction

endpackage

### rtl/tdc_coincidence_histogram.sv
// Top level of the TDC coincidence histogram.
// Takes one beat per clock while the operation queue is not full: an event
// word, a read of one bin or counter, or a clear. Events on channel 2, channel 4
// or both are counted, and a 4-after-2 or 2-after-4 pair of consecutive events
// within the half window lands in the histogram bin at centre plus or minus the
// tick difference; a both-channel event adds to the centre bin. All counts
// saturate. Throughput is one beat per cycle unless a queue stalls, set by the
// bin read-modify-write in the back end; a read result is registered in the
// operation queue, then the result queue. A two-entry operation queue and a
// two-entry result queue let either side stall without stopping the other.
module tdc_coincidence_histogram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [tch_pkg::CMD_W-1:0]  i_command,
    input  logic [tch_pkg::WORD_W-1:0] i_event_word,
    input  logic [tch_pkg::IDX_W-1:0]  i_read_index,
    output logic                       empty,
    input  logic                       pop,
    output logic [tch_pkg::VAL_W-1:0]  o_read_value
);

    logic         accept;
    logic         op_valid;
    tch_pkg::t_op front_op;
    tch_pkg::t_op head_op;
    logic         op_empty;
    logic         op_pop;

    assign accept = push && !full;

    tch_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_event_word (i_event_word),
        .i_read_index (i_read_index),
        .o_op_valid   (op_valid),
        .o_op         (front_op)
    );

    tch_op_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && op_valid),
        .i_op    (front_op),
        .i_pop   (op_pop),
        .o_full  (full),
        .o_empty (op_empty),
        .o_op    (head_op)
    );

    tch_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_empty   (op_empty),
        .i_op         (head_op),
        .o_op_pop     (op_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_read_value (o_read_value)
    );

endmodule

### rtl/tch_front.sv
// Front end: decodes commands and pairs consecutive events into bin updates.
module tch_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [tch_pkg::CMD_W-1:0]   i_command,
    input  logic [tch_pkg::WORD_W-1:0]  i_event_word,
    input  logic [tch_pkg::IDX_W-1:0]   i_read_index,
    output logic                        o_op_valid,
    output tch_pkg::t_op                o_op
);

    logic [tch_pkg::TICK_W-1:0] r_last_ticks;
    logic [tch_pkg::PAT_W-1:0]  r_last_pat;
    logic                       r_have_last;

    logic [tch_pkg::PAT_W-1:0]  pat;
    logic [tch_pkg::TICK_W-1:0] ticks;
    logic [tch_pkg::TICK_W-1:0] diff;
    logic                       pair_ok;
    logic                       is_event;

    assign pat      = i_event_word[tch_pkg::PAT_W-1:0];
    assign ticks    = i_event_word[tch_pkg::WORD_W-1:tch_pkg::PAT_W];
    assign diff     = ticks - r_last_ticks;
    assign pair_ok  = r_have_last && (ticks >= r_last_ticks)
                      && (diff <= tch_pkg::TICK_W'(tch_pkg::HALF_WINDOW));
    assign is_event = (tch_pkg::t_cmd'(i_command) == tch_pkg::CMD_EVENT);

    always_comb begin
        o_op          = '0;
        o_op.kind     = tch_pkg::OP_BUMP;
        o_op.sel      = tch_pkg::SEL_NONE;
        o_op.bin_addr = tch_pkg::BIN_W'(tch_pkg::CENTRE_BIN);
        o_op_valid    = 1'b0;
        unique case (tch_pkg::t_cmd'(i_command))
            tch_pkg::CMD_EVENT: begin
                o_op.kind = tch_pkg::OP_BUMP;
                if (pat == tch_pkg::PAT_BOTH) begin
                    o_op.bin_en  = 1'b1;
                    o_op.ch2_inc = 1'b1;
                    o_op.ch4_inc = 1'b1;
                end else if (pat == tch_pkg::PAT_CH4) begin
                    o_op.ch4_inc = 1'b1;
                    if (pair_ok && r_last_pat == tch_pkg::PAT_CH2) begin
                        o_op.bin_en   = 1'b1;
                        o_op.bin_addr = tch_pkg::BIN_W'(tch_pkg::CENTRE_BIN)
                                        + diff[tch_pkg::BIN_W-1:0];
                    end
                end else if (pat == tch_pkg::PAT_CH2) begin
                    o_op.ch2_inc = 1'b1;
                    if (pair_ok && r_last_pat == tch_pkg::PAT_CH4) begin
                        o_op.bin_en   = 1'b1;
                        o_op.bin_addr = tch_pkg::BIN_W'(tch_pkg::CENTRE_BIN)
                                        - diff[tch_pkg::BIN_W-1:0];
                    end
                end
                o_op_valid = o_op.bin_en | o_op.ch2_inc | o_op.ch4_inc;
            end
            tch_pkg::CMD_READ: begin
                o_op.kind     = tch_pkg::OP_READ;
                o_op.bin_addr = tch_pkg::BIN_W'(i_read_index);
                if (int'(i_read_index) < tch_pkg::NUM_BINS) begin
                    o_op.sel = tch_pkg::SEL_BIN;
                end else if (int'(i_read_index) == tch_pkg::NUM_BINS) begin
                    o_op.sel = tch_pkg::SEL_CH2;
                end else if (int'(i_read_index) == tch_pkg::NUM_BINS + 1) begin
                    o_op.sel = tch_pkg::SEL_CH4;
                end else begin
                    o_op.sel = tch_pkg::SEL_NONE;
                end
                o_op_valid = 1'b1;
            end
            tch_pkg::CMD_CLEAR: begin
                o_op.kind  = tch_pkg::OP_CLEAR;
                o_op_valid = 1'b1;
            end
            tch_pkg::CMD_NONE: begin
                o_op_valid = 1'b0;
            end
            default: begin
                o_op_valid = 1'b0;
            end
        endcase
    end

    // every event becomes the previous one, whatever its pattern
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ticks <= '0;
            r_last_pat   <= '0;
            r_have_last  <= 1'b0;
        end else if (i_accept && is_event) begin
            r_last_ticks <= ticks;
            r_last_pat   <= pat;
            r_have_last  <= 1'b1;
        end
    end

endmodule

### rtl/tch_op_queue.sv
// Two-entry queue of decoded operations between front and back end.
module tch_op_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  tch_pkg::t_op i_op,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output tch_pkg::t_op o_op
);

    tch_pkg::t_op r_mem [0:1];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_cnt;
    logic [1:0]   n_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

### rtl/tch_back.sv
// Back end: histogram bins, channel counters and the result queue.
module tch_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_op_empty,
    input  tch_pkg::t_op               i_op,
    output logic                       o_op_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [tch_pkg::VAL_W-1:0]  o_read_value
);

    tch_pkg::t_count             r_bins [0:tch_pkg::NUM_BINS-1];
    tch_pkg::t_count             r_ch2;
    tch_pkg::t_count             r_ch4;
    logic [tch_pkg::VAL_W-1:0]   r_res [0:1];
    logic                        r_res_wr;
    logic                        r_res_rd;
    logic [1:0]                  r_res_cnt;
    logic [1:0]                  n_res_cnt;

    tch_pkg::t_count             cur_bin;
    logic [tch_pkg::VAL_W-1:0]   rd_value;
    logic                        res_full;
    logic                        take;
    logic                        res_push;
    logic                        res_pop;

    assign res_full = (r_res_cnt == 2'd2);
    assign take     = !i_op_empty && ((i_op.kind != tch_pkg::OP_READ) || !res_full);
    assign o_op_pop = take;
    assign res_push = take && (i_op.kind == tch_pkg::OP_READ);
    assign res_pop  = i_pop && (r_res_cnt != 2'd0);
    assign cur_bin  = r_bins[i_op.bin_addr];

    assign o_empty      = (r_res_cnt == 2'd0);
    assign o_read_value = r_res[r_res_rd];

    always_comb begin
        unique case (i_op.sel)
            tch_pkg::SEL_BIN:  rd_value = tch_pkg::clip_value(cur_bin);
            tch_pkg::SEL_CH2:  rd_value = tch_pkg::clip_value(r_ch2);
            tch_pkg::SEL_CH4:  rd_value = tch_pkg::clip_value(r_ch4);
            tch_pkg::SEL_NONE: rd_value = '0;
            default:           rd_value = '0;
        endcase
    end

    always_comb begin
        n_res_cnt = r_res_cnt;
        if (res_push && !res_pop) begin
            n_res_cnt = r_res_cnt + 2'd1;
        end else if (res_pop && !res_push) begin
            n_res_cnt = r_res_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tch_pkg::NUM_BINS; i++) begin
                r_bins[i] <= '0;
            end
            r_ch2 <= '0;
            r_ch4 <= '0;
        end else if (take) begin
            unique case (i_op.kind)
                tch_pkg::OP_CLEAR: begin
                    for (int i = 0; i < tch_pkg::NUM_BINS; i++) begin
                        r_bins[i] <= '0;
                    end
                    r_ch2 <= '0;
                    r_ch4 <= '0;
                end
                tch_pkg::OP_BUMP: begin
                    // single bin touched per event, so one read-modify-write
                    if (i_op.bin_en) begin
                        r_bins[i_op.bin_addr] <= tch_pkg::sat_inc(cur_bin);
                    end
                    if (i_op.ch2_inc) begin
                        r_ch2 <= tch_pkg::sat_inc(r_ch2);
                    end
                    if (i_op.ch4_inc) begin
                        r_ch4 <= tch_pkg::sat_inc(r_ch4);
                    end
                end
                tch_pkg::OP_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr  <= 1'b0;
            r_res_rd  <= 1'b0;
            r_res_cnt <= '0;
        end else begin
            r_res_cnt <= n_res_cnt;
            if (res_push) begin
                r_res_wr <= ~r_res_wr;
            end
            if (res_pop) begin
                r_res_rd <= ~r_res_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wr] <= rd_value;
        end
    end

endmodule
